// ===== design/mcq_pkg.sv =====
// Package: shared types, codes and tables of the mixing constant qualifier.
`default_nettype none
package mcq_pkg;

  localparam int WordW = 32;
  localparam int DivW  = 16;

  localparam logic [2:0] VerdictPass    = 3'd0;
  localparam logic [2:0] VerdictPopcnt  = 3'd1;
  localparam logic [2:0] VerdictWinBits = 3'd2;
  localparam logic [2:0] VerdictWinRep  = 3'd3;
  localparam logic [2:0] VerdictNoPrime = 3'd4;

  localparam logic [1:0] CfgPopcount = 2'd0;
  localparam logic [1:0] CfgWinMin   = 2'd1;
  localparam logic [1:0] CfgWinMax   = 2'd2;

  localparam int TrialLimit = 65536;
  localparam int NumPrimes  = 54;
  localparam logic [5:0] PrimeLast = 6'(NumPrimes - 1);
  localparam logic [DivW-1:0] OddFirst = 16'd257;
  localparam logic [DivW-1:0] OddLast  = DivW'(TrialLimit - 1);

  localparam logic [7:0] Primes [NumPrimes] = '{
    8'd2, 8'd3, 8'd5, 8'd7, 8'd11, 8'd13, 8'd17, 8'd19, 8'd23, 8'd29, 8'd31,
    8'd37, 8'd41, 8'd43, 8'd47, 8'd53, 8'd59, 8'd61, 8'd67, 8'd71, 8'd73,
    8'd79, 8'd83, 8'd89, 8'd97, 8'd101, 8'd103, 8'd107, 8'd109, 8'd113,
    8'd127, 8'd131, 8'd137, 8'd139, 8'd149, 8'd151, 8'd157, 8'd163, 8'd167,
    8'd173, 8'd179, 8'd181, 8'd191, 8'd193, 8'd197, 8'd199, 8'd211, 8'd223,
    8'd227, 8'd229, 8'd233, 8'd239, 8'd241, 8'd251
  };

  typedef struct packed {
    logic [WordW-1:0] word;
    logic [2:0]       verdict;
    logic             trial;
  } q_entry_t;

  typedef struct packed {
    logic [5:0] popcount;
    logic [3:0] win_min;
    logic [3:0] win_max;
  } cfg_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage
`default_nettype wire

// ===== design/mcq_front.sv =====
// Front: accepts candidates, runs popcount and window scans.
`default_nettype none
module mcq_front (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  mcq_pkg::cfg_t         cfg_i,
  input  wire                   in_valid_i,
  output logic                  in_stall_o,
  input  wire  [31:0]           candidate_i,
  input  mcq_pkg::q_status_t    q_status_i,
  output logic                  push_o,
  output mcq_pkg::q_entry_t     push_data_o
);

  localparam logic [1:0] FIdle = 2'd0;
  localparam logic [1:0] FScan = 2'd1;
  localparam logic [1:0] FPush = 2'd2;

  logic [1:0]   state_q;
  logic [31:0]  word_q, rot_q;
  logic [4:0]   r_q;
  logic         bits_fail_q, rep_fail_q;
  logic [2:0]   verdict_q;
  logic [5:0]   pop;
  logic [3:0]   wpop;
  logic [7:0]   win;
  logic         bits_bad, rep_hit, accept;

  always_comb begin
    logic [31:0] rot_s;
    pop = '0;
    for (int i = 0; i < 32; i++) pop = pop + 6'(candidate_i[i]);
    win  = rot_q[7:0];
    wpop = '0;
    for (int i = 0; i < 8; i++) wpop = wpop + 4'(win[i]);
    // current window against every earlier window of the held word
    rep_hit = 1'b0;
    for (int s = 0; s < 31; s++) begin
      rot_s = (word_q << s) | (word_q >> (32 - s));
      if ((5'(s) < r_q) && (win == rot_s[7:0])) rep_hit = 1'b1;
    end
  end

  assign bits_bad    = (wpop < cfg_i.win_min) || (wpop > cfg_i.win_max);
  assign in_stall_o  = (state_q != FIdle);
  assign accept      = in_valid_i && !in_stall_o;
  assign push_o      = (state_q == FPush) && !q_status_i.full;
  assign push_data_o = '{word: word_q, verdict: verdict_q,
                         trial: (verdict_q == mcq_pkg::VerdictPass)};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FIdle;
    end else begin
      unique case (state_q)
        FIdle: if (accept) state_q <= (pop != cfg_i.popcount) ? FPush : FScan;
        FScan: if (r_q == 5'd31) state_q <= FPush;
        FPush: if (!q_status_i.full) state_q <= FIdle;
        default: state_q <= FIdle;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      word_q      <= candidate_i;
      rot_q       <= candidate_i;
      r_q         <= '0;
      bits_fail_q <= 1'b0;
      rep_fail_q  <= 1'b0;
      verdict_q   <= mcq_pkg::VerdictPopcnt;
    end else if (state_q == FScan) begin
      rot_q       <= {rot_q[30:0], rot_q[31]};
      r_q         <= r_q + 5'd1;
      bits_fail_q <= bits_fail_q | bits_bad;
      rep_fail_q  <= rep_fail_q | rep_hit;
      if (r_q == 5'd31) begin
        if (bits_fail_q || bits_bad) verdict_q <= mcq_pkg::VerdictWinBits;
        else if (rep_fail_q || rep_hit) verdict_q <= mcq_pkg::VerdictWinRep;
        else verdict_q <= mcq_pkg::VerdictPass;
      end
    end
  end

endmodule
`default_nettype wire

// ===== design/mcq_queue.sv =====
// Two-entry queue between front and back.
`default_nettype none
module mcq_queue (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   push_i,
  input  mcq_pkg::q_entry_t     push_data_i,
  input  wire                   pop_i,
  output mcq_pkg::q_entry_t     pop_data_o,
  output mcq_pkg::q_status_t    status_o
);

  mcq_pkg::q_entry_t mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;

  assign pop_data_o     = mem_q[rp_q];
  assign status_o.full  = (cnt_q == 2'd2);
  assign status_o.empty = (cnt_q == 2'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= ~wp_q;
      if (pop_i) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= push_data_i;
  end

endmodule
`default_nettype wire

// ===== design/mcq_back.sv =====
// Back: bit-serial trial division and the result register.
`default_nettype none
module mcq_back (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  mcq_pkg::q_status_t    q_status_i,
  input  mcq_pkg::q_entry_t     pop_data_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  wire                   out_stall_i,
  output logic [2:0]            verdict_o,
  output logic [31:0]           complement_o
);

  localparam logic BIdle = 1'b0;
  localparam logic BDiv  = 1'b1;

  logic        state_q, out_valid_q, phase_q;
  logic [31:0] word_q;
  logic [2:0]  verdict_q;
  logic [5:0]  idx_q;
  logic [15:0] d_q, rem_q;
  logic [4:0]  cnt_q;
  logic [16:0] rem_sh, rem_n;
  logic        last_div;

  assign pop_o        = (state_q == BIdle) && !out_valid_q && !q_status_i.empty;
  assign out_valid_o  = out_valid_q;
  assign verdict_o    = verdict_q;
  assign complement_o = ~word_q;

  assign rem_sh   = {rem_q, word_q[~cnt_q]};
  assign rem_n    = (rem_sh >= {1'b0, d_q}) ? rem_sh - {1'b0, d_q} : rem_sh;
  assign last_div = !phase_q && (d_q == mcq_pkg::OddLast);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BIdle;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
      unique case (state_q)
        BIdle: begin
          if (pop_o) begin
            if (pop_data_i.trial) state_q <= BDiv;
            else out_valid_q <= 1'b1;
          end
        end
        BDiv: begin
          if (cnt_q == 5'd31 && (rem_n == '0 || last_div)) begin
            state_q     <= BIdle;
            out_valid_q <= 1'b1;
          end
        end
        default: state_q <= BIdle;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      word_q    <= pop_data_i.word;
      verdict_q <= pop_data_i.verdict;
      phase_q   <= 1'b1;
      idx_q     <= '0;
      d_q       <= {8'd0, mcq_pkg::Primes[0]};
      cnt_q     <= '0;
      rem_q     <= '0;
    end else if (state_q == BDiv) begin
      cnt_q <= cnt_q + 5'd1;
      if (cnt_q == 5'd31) begin
        rem_q <= '0;
        if (rem_n == '0) begin
          verdict_q <= mcq_pkg::VerdictNoPrime;
        end else if (phase_q) begin
          if (idx_q == mcq_pkg::PrimeLast) begin
            phase_q <= 1'b0;
            d_q     <= mcq_pkg::OddFirst;
          end else begin
            idx_q <= idx_q + 6'd1;
            d_q   <= {8'd0, mcq_pkg::Primes[idx_q + 6'd1]};
          end
        end else begin
          d_q <= d_q + 16'd2;
        end
      end else begin
        rem_q <= rem_n[15:0];
      end
    end
  end

endmodule
`default_nettype wire

// ===== design/mixing_constant_qualifier.sv =====
// Top level: configuration registers and front/queue/back hookup.
//
//  channel | ports                                   | direction
//  in      | in_valid_i, in_stall_o, candidate_i     | item in
//  out     | out_valid_o, out_stall_i, verdict_o,     | result out
//          | complement_o                            |
//  cfg     | cfg_we_i, cfg_index_i, cfg_data_i       | register write
//
// Front: a popcount fail goes straight to a push, else a window scan, then a push.
// Back: trial divisors run in turn through one serial remainder unit; a full
// trial covers 54 primes and 32640 odd divisors.
// Reset clears control state and loads registers to 16, 3 and 5.
// Either side stalls independently; the two-entry queue parts them.
`default_nettype none
module mixing_constant_qualifier (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         cfg_we_i,
  input  wire  [1:0]  cfg_index_i,
  input  wire  [5:0]  cfg_data_i,
  input  wire         in_valid_i,
  output logic        in_stall_o,
  input  wire  [31:0] candidate_i,
  output logic        out_valid_o,
  input  wire         out_stall_i,
  output logic [2:0]  verdict_o,
  output logic [31:0] complement_o
);

  mcq_pkg::cfg_t      cfg_q;
  mcq_pkg::q_status_t q_status;
  mcq_pkg::q_entry_t  push_data, pop_data;
  logic               push, pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{popcount: 6'd16, win_min: 4'd3, win_max: 4'd5};
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        mcq_pkg::CfgPopcount: cfg_q.popcount <= cfg_data_i;
        mcq_pkg::CfgWinMin:   cfg_q.win_min  <= cfg_data_i[3:0];
        mcq_pkg::CfgWinMax:   cfg_q.win_max  <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  mcq_front u_front (
    .clk_i, .rst_ni,
    .cfg_i       (cfg_q),
    .in_valid_i,
    .in_stall_o,
    .candidate_i,
    .q_status_i  (q_status),
    .push_o      (push),
    .push_data_o (push_data)
  );

  mcq_queue u_queue (
    .clk_i, .rst_ni,
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .status_o    (q_status)
  );

  mcq_back u_back (
    .clk_i, .rst_ni,
    .q_status_i  (q_status),
    .pop_data_i  (pop_data),
    .pop_o       (pop),
    .out_valid_o,
    .out_stall_i,
    .verdict_o,
    .complement_o
  );

endmodule
`default_nettype wire
